// ===== rtl/hrlp_pkg.sv =====
`timescale 1ns / 1ps

package hrlp_pkg;

	localparam int FIELD_W             = 16;
	localparam int DEFAULT_LENGTH_BITS = 16;
	localparam int DEFAULT_MIN_LENGTH  = 10;
	localparam int DEFAULT_QUEUE_DEPTH = 2;
	localparam int NUM_METHODS         = 8;
	localparam int METHOD_SPAN         = 8;

	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_SP  = 8'h20;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_MALFORMED  = 2'd1,
		ST_INCOMPLETE = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		M_OPTIONS = 3'd0,
		M_GET     = 3'd1,
		M_HEAD    = 3'd2,
		M_POST    = 3'd3,
		M_PUT     = 3'd4,
		M_DELETE  = 3'd5,
		M_TRACE   = 3'd6,
		M_CONNECT = 3'd7
	} method_t;

	// one classified payload byte on its way to the parser back end
	typedef struct packed {
		logic                   first;
		logic [FIELD_W-1:0]     msg_len;
		logic                   is_ws;
		logic                   is_cr;
		logic                   is_lf;
		logic                   is_nul;
		logic [NUM_METHODS-1:0] meth_cont;
		logic [NUM_METHODS-1:0] meth_term;
	} entry_t;

	typedef struct packed {
		status_t            status;
		logic [2:0]         method;
		logic [FIELD_W-1:0] uri_off;
		logic [FIELD_W-1:0] uri_len;
		logic [FIELD_W-1:0] ver_off;
		logic [FIELD_W-1:0] ver_len;
		logic [FIELD_W-1:0] body_off;
		logic               has_body;
	} result_t;

	function automatic logic [3:0] meth_len(input logic [2:0] k);
		logic [3:0] n;
		case (k)
			M_OPTIONS: n = 4'd7;
			M_GET:     n = 4'd3;
			M_HEAD:    n = 4'd4;
			M_POST:    n = 4'd4;
			M_PUT:     n = 4'd3;
			M_DELETE:  n = 4'd6;
			M_TRACE:   n = 4'd5;
			M_CONNECT: n = 4'd7;
			default:   n = 4'd0;
		endcase
		return n;
	endfunction

	// character idx of method k; first character sits in the top byte
	function automatic logic [7:0] meth_char(input logic [2:0] k, input logic [2:0] idx);
		logic [63:0] text;
		case (k)
			M_OPTIONS: text = {"OPTIONS", 8'h00};
			M_GET:     text = {"GET", 40'h0};
			M_HEAD:    text = {"HEAD", 32'h0};
			M_POST:    text = {"POST", 32'h0};
			M_PUT:     text = {"PUT", 40'h0};
			M_DELETE:  text = {"DELETE", 16'h0};
			M_TRACE:   text = {"TRACE", 24'h0};
			M_CONNECT: text = {"CONNECT", 8'h00};
			default:   text = '0;
		endcase
		return text[8 * (3'd7 - idx) +: 8];
	endfunction

endpackage

// ===== rtl/hrlp_front.sv =====
`timescale 1ns / 1ps

module hrlp_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         byte_valid,
	output logic                         byte_ready,
	input  logic [7:0]                   data_byte,
	input  logic                         first_byte,
	input  logic [hrlp_pkg::FIELD_W-1:0] message_length,
	input  logic                         q_full,
	output logic                         q_push,
	output hrlp_pkg::entry_t             q_wdata
);

	localparam logic [3:0] SPAN = 4'(hrlp_pkg::METHOD_SPAN);

	// byte count since the first byte, saturating past the longest method name
	logic [3:0] mpos_q;
	logic [3:0] pos_now;

	assign byte_ready = !q_full;
	assign q_push     = byte_valid && !q_full;
	assign pos_now    = first_byte ? 4'd0 : mpos_q;

	always_comb begin
		q_wdata         = '0;
		q_wdata.first   = first_byte;
		q_wdata.msg_len = message_length;
		q_wdata.is_ws   = data_byte inside {hrlp_pkg::CH_SP, [hrlp_pkg::CH_TAB:hrlp_pkg::CH_CR]};
		q_wdata.is_cr   = data_byte == hrlp_pkg::CH_CR;
		q_wdata.is_lf   = data_byte == hrlp_pkg::CH_LF;
		q_wdata.is_nul  = data_byte == hrlp_pkg::CH_NUL;
		for (int k = 0; k < hrlp_pkg::NUM_METHODS; k++) begin
			q_wdata.meth_cont[k] = (pos_now < hrlp_pkg::meth_len(3'(k))) &&
				(data_byte == hrlp_pkg::meth_char(3'(k), pos_now[2:0]));
			q_wdata.meth_term[k] = (pos_now == hrlp_pkg::meth_len(3'(k))) &&
				(data_byte == hrlp_pkg::CH_SP);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mpos_q <= '0;
		end else if (q_push) begin
			mpos_q <= (pos_now == SPAN) ? SPAN : pos_now + 4'd1;
		end
	end

endmodule

// ===== rtl/hrlp_fifo.sv =====
`timescale 1ns / 1ps

module hrlp_fifo #(
	parameter int DEPTH = hrlp_pkg::DEFAULT_QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  hrlp_pkg::entry_t push_data,
	input  logic             pop,
	output hrlp_pkg::entry_t pop_data,
	output logic             full,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

	hrlp_pkg::entry_t slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full     = count_q == CNT_W'(DEPTH);
	assign empty    = count_q == '0;
	assign pop_data = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/hrlp_back.sv =====
`timescale 1ns / 1ps

module hrlp_back #(
	parameter int LENGTH_BITS = hrlp_pkg::DEFAULT_LENGTH_BITS,
	parameter int MIN_LENGTH  = hrlp_pkg::DEFAULT_MIN_LENGTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	input  hrlp_pkg::entry_t  q_data,
	output logic              q_pop,
	output logic              out_valid,
	input  logic              out_ready,
	output hrlp_pkg::result_t out_res
);

	localparam int LB = LENGTH_BITS;
	localparam int FW = hrlp_pkg::FIELD_W;

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_METHOD,
		PH_SKIP1,
		PH_SKIP1_CR,
		PH_URI,
		PH_URI_CR,
		PH_VSKIP,
		PH_VSKIP_CR,
		PH_VER,
		PH_VER_CR,
		PH_BODY,
		PH_DONE
	} phase_t;

	phase_t            phase_q;
	logic [LB-1:0]     pos_q, total_q, tok_q;
	logic [LB-1:0]     uri_off_q, uri_len_q, ver_off_q, ver_len_q;
	logic [7:0]        cand_q;
	logic              out_valid_q;
	hrlp_pkg::result_t res_q;

	phase_t            cur_phase, eff, n_phase;
	logic [LB-1:0]     cur_pos, cur_total, cur_tok;
	logic [LB-1:0]     cur_uri_off, cur_uri_len, cur_ver_off, cur_ver_len;
	logic [7:0]        cur_cand, n_cand, hit;
	logic [LB-1:0]     n_pos, n_tok, n_uri_off, n_uri_len, n_ver_off, n_ver_len;
	logic [LB-1:0]     lim, p_prev;
	logic              at_end, prev_end, emit, has;
	hrlp_pkg::status_t st;
	logic [LB-1:0]     body;
	hrlp_pkg::result_t res_n;
	logic              take;

	assign take      = !q_empty && (!out_valid_q || out_ready);
	assign q_pop     = take;
	assign out_valid = out_valid_q;
	assign out_res   = res_q;

	always_comb begin
		cur_phase   = phase_q;
		cur_pos     = pos_q;
		cur_total   = total_q;
		cur_tok     = tok_q;
		cur_cand    = cand_q;
		cur_uri_off = uri_off_q;
		cur_uri_len = uri_len_q;
		cur_ver_off = ver_off_q;
		cur_ver_len = ver_len_q;
		if (q_data.first) begin
			cur_phase   = PH_METHOD;
			cur_pos     = '0;
			cur_total   = LB'(q_data.msg_len);
			cur_tok     = '0;
			cur_cand    = '1;
			cur_uri_off = '0;
			cur_uri_len = '0;
			cur_ver_off = '0;
			cur_ver_len = '0;
		end

		lim       = cur_total - LB'(2);
		p_prev    = cur_pos - LB'(1);
		at_end    = cur_pos >= lim;
		prev_end  = p_prev >= lim;
		hit       = cur_cand & q_data.meth_term;
		n_pos     = cur_pos;
		n_tok     = cur_tok;
		n_cand    = cur_cand;
		n_uri_off = cur_uri_off;
		n_uri_len = cur_uri_len;
		n_ver_off = cur_ver_off;
		n_ver_len = cur_ver_len;
		n_phase   = cur_phase;
		eff       = cur_phase;
		emit      = 1'b0;
		st        = hrlp_pkg::ST_OK;
		body      = '0;
		has       = 1'b0;

		if (q_data.first && cur_total <= LB'(MIN_LENGTH)) begin
			emit    = 1'b1;
			st      = hrlp_pkg::ST_MALFORMED;
			n_phase = PH_DONE;
		end else if (cur_phase != PH_IDLE && cur_phase != PH_DONE && cur_pos < cur_total) begin
			n_pos = cur_pos + LB'(1);
			// a CR without LF hands this byte to the skip phase, save at the URI end
			case (cur_phase)
				PH_SKIP1_CR: if (!q_data.is_lf) eff = PH_SKIP1;
				PH_VSKIP_CR: if (!q_data.is_lf) eff = PH_VSKIP;
				PH_URI_CR:   if (!q_data.is_lf && !prev_end) eff = PH_VSKIP;
				default:     eff = cur_phase;
			endcase
			n_phase = eff;

			case (eff)
				PH_METHOD: begin
					if (hit != '0) begin
						n_cand = hit & (~hit + 8'd1);
						if (at_end) begin
							emit = 1'b1; st = hrlp_pkg::ST_MALFORMED; n_phase = PH_DONE;
						end else begin
							n_phase = PH_SKIP1;
						end
					end else begin
						n_cand = cur_cand & q_data.meth_cont;
						if (n_cand == '0) begin
							emit = 1'b1; st = hrlp_pkg::ST_MALFORMED; n_phase = PH_DONE;
						end
					end
				end
				PH_SKIP1: begin
					if (at_end || q_data.is_nul) begin
						emit = 1'b1; st = hrlp_pkg::ST_MALFORMED; n_phase = PH_DONE;
					end else if (q_data.is_ws) begin
						if (q_data.is_cr) n_phase = PH_SKIP1_CR;
					end else begin
						n_tok   = cur_pos;
						n_phase = PH_URI;
					end
				end
				PH_SKIP1_CR, PH_VSKIP_CR: begin
					// CR LF before a token
					emit = 1'b1; st = hrlp_pkg::ST_MALFORMED; n_phase = PH_DONE;
				end
				PH_URI: begin
					if (!q_data.is_ws && !q_data.is_nul) begin
						if (at_end) begin
							emit = 1'b1; st = hrlp_pkg::ST_MALFORMED; n_phase = PH_DONE;
						end
					end else begin
						n_uri_off = cur_tok;
						n_uri_len = cur_pos - cur_tok;
						if (q_data.is_nul || (!q_data.is_cr && at_end)) begin
							emit = 1'b1; st = hrlp_pkg::ST_MALFORMED; n_phase = PH_DONE;
						end else if (q_data.is_cr) begin
							n_phase = PH_URI_CR;
						end else begin
							n_phase = PH_VSKIP;
						end
					end
				end
				PH_URI_CR: begin
					emit    = prev_end;
					n_phase = prev_end ? PH_DONE : PH_BODY;
					st      = q_data.is_lf ? hrlp_pkg::ST_INCOMPLETE : hrlp_pkg::ST_MALFORMED;
				end
				PH_VSKIP: begin
					if (at_end) begin
						emit = 1'b1; st = hrlp_pkg::ST_MALFORMED; n_phase = PH_DONE;
					end else if (q_data.is_ws) begin
						if (q_data.is_cr) n_phase = PH_VSKIP_CR;
					end else begin
						n_tok   = cur_pos;
						n_phase = PH_VER;
					end
				end
				PH_VER: begin
					if (!q_data.is_ws) begin
						if (at_end) begin
							emit = 1'b1; st = hrlp_pkg::ST_MALFORMED; n_phase = PH_DONE;
						end
					end else begin
						n_ver_off = cur_tok;
						n_ver_len = cur_pos - cur_tok;
						if (at_end) begin
							emit = 1'b1; st = hrlp_pkg::ST_INCOMPLETE; n_phase = PH_DONE;
						end else if (!q_data.is_cr) begin
							emit = 1'b1; st = hrlp_pkg::ST_MALFORMED; n_phase = PH_DONE;
						end else begin
							n_phase = PH_VER_CR;
						end
					end
				end
				PH_VER_CR: begin
					if (!q_data.is_lf) begin
						emit = 1'b1; st = hrlp_pkg::ST_MALFORMED; n_phase = PH_DONE;
					end else begin
						n_phase = PH_BODY;
					end
				end
				PH_BODY: begin
					emit    = 1'b1;
					st      = hrlp_pkg::ST_OK;
					body    = cur_pos;
					has     = !q_data.is_nul;
					n_phase = PH_DONE;
				end
				default: n_phase = PH_DONE;
			endcase
		end

		res_n        = '0;
		res_n.status = st;
		if (st == hrlp_pkg::ST_OK) begin
			for (int k = hrlp_pkg::NUM_METHODS - 1; k >= 0; k--) begin
				if (cur_cand[k]) res_n.method = 3'(k);
			end
			res_n.uri_off  = FW'(cur_uri_off);
			res_n.uri_len  = FW'(cur_uri_len);
			res_n.ver_off  = FW'(cur_ver_off);
			res_n.ver_len  = FW'(cur_ver_len);
			res_n.body_off = FW'(body);
			res_n.has_body = has;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			pos_q       <= '0;
			total_q     <= '0;
			tok_q       <= '0;
			cand_q      <= '1;
			uri_off_q   <= '0;
			uri_len_q   <= '0;
			ver_off_q   <= '0;
			ver_len_q   <= '0;
			out_valid_q <= 1'b0;
			res_q       <= '0;
		end else if (take) begin
			phase_q     <= n_phase;
			pos_q       <= n_pos;
			total_q     <= cur_total;
			tok_q       <= n_tok;
			cand_q      <= n_cand;
			uri_off_q   <= n_uri_off;
			uri_len_q   <= n_uri_len;
			ver_off_q   <= n_ver_off;
			ver_len_q   <= n_ver_len;
			out_valid_q <= emit;
			res_q       <= res_n;
		end else if (out_valid_q && out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

`ifndef SYNTHESIS
	a_quiet_when_decided: assert property (@(posedge clk) disable iff (!arst_n)
		(take && !q_data.first && (phase_q == PH_IDLE || phase_q == PH_DONE))
		|=> !out_valid_q)
		else $error("result produced for a byte outside any message");

	a_pos_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_IDLE && phase_q != PH_DONE) |-> pos_q <= total_q)
		else $error("position ran past message length");

	a_ok_one_method: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.status == hrlp_pkg::ST_OK) |-> $onehot(cand_q))
		else $error("accepted request without a single method");

	a_fail_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.status != hrlp_pkg::ST_OK)
		|-> (res_q.uri_len == '0 && res_q.body_off == '0 && !res_q.has_body))
		else $error("failed result carries field data");
`endif

endmodule

// ===== rtl/http_request_line_parser.sv =====
`timescale 1ns / 1ps

// channel   handshake                    payload
// input     byte_valid / byte_ready      data_byte, first_byte, message_length
// output    result_valid / result_ready  parse_status, method_index, uri_offset, uri_length,
//                                        version_offset, version_length, body_offset, has_body
//
// One byte per cycle while the queue is not full; the back end decides one byte per
// cycle while no result is stalled. Results register as the deciding byte is popped.
// Reset empties the queue and leaves the parser idle until a first byte.
// byte_ready drops only when the QUEUE_DEPTH-entry queue is full; a stalled
// result holds the back end while the front keeps filling the queue.
module http_request_line_parser #(
	parameter int LENGTH_BITS = hrlp_pkg::DEFAULT_LENGTH_BITS,
	parameter int MIN_LENGTH  = hrlp_pkg::DEFAULT_MIN_LENGTH,
	parameter int QUEUE_DEPTH = hrlp_pkg::DEFAULT_QUEUE_DEPTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         byte_valid,
	output logic                         byte_ready,
	input  logic [7:0]                   data_byte,
	input  logic                         first_byte,
	input  logic [hrlp_pkg::FIELD_W-1:0] message_length,
	output logic                         result_valid,
	input  logic                         result_ready,
	output logic [1:0]                   parse_status,
	output logic [2:0]                   method_index,
	output logic [hrlp_pkg::FIELD_W-1:0] uri_offset,
	output logic [hrlp_pkg::FIELD_W-1:0] uri_length,
	output logic [hrlp_pkg::FIELD_W-1:0] version_offset,
	output logic [hrlp_pkg::FIELD_W-1:0] version_length,
	output logic [hrlp_pkg::FIELD_W-1:0] body_offset,
	output logic                         has_body
);

	hrlp_pkg::entry_t  wdata, rdata;
	hrlp_pkg::result_t res;
	logic              push, pop, full, empty;

	hrlp_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.byte_valid     (byte_valid),
		.byte_ready     (byte_ready),
		.data_byte      (data_byte),
		.first_byte     (first_byte),
		.message_length (message_length),
		.q_full         (full),
		.q_push         (push),
		.q_wdata        (wdata)
	);

	hrlp_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (wdata),
		.pop       (pop),
		.pop_data  (rdata),
		.full      (full),
		.empty     (empty)
	);

	hrlp_back #(
		.LENGTH_BITS (LENGTH_BITS),
		.MIN_LENGTH  (MIN_LENGTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (empty),
		.q_data    (rdata),
		.q_pop     (pop),
		.out_valid (result_valid),
		.out_ready (result_ready),
		.out_res   (res)
	);

	assign parse_status   = res.status;
	assign method_index   = res.method;
	assign uri_offset     = res.uri_off;
	assign uri_length     = res.uri_len;
	assign version_offset = res.ver_off;
	assign version_length = res.ver_len;
	assign body_offset    = res.body_off;
	assign has_body       = res.has_body;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import hrlp_pkg::*;

	localparam int MIN_LEN  = DEFAULT_MIN_LENGTH;
	localparam int WATCHDOG = 2000;

	typedef enum logic [3:0] {
		LP_IDLE, LP_METHOD, LP_SKIP_URI, LP_SKIP_URI_CR, LP_URI, LP_URI_CR,
		LP_SKIP_VER, LP_SKIP_VER_CR, LP_VER, LP_VER_CR, LP_BODY, LP_DONE
	} line_phase_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic byte_valid = 1'b0;
	logic byte_ready;
	logic [7:0] data_byte = 8'h00;
	logic first_byte = 1'b0;
	logic [FIELD_W-1:0] message_length = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	logic [1:0] parse_status;
	logic [2:0] method_index;
	logic [FIELD_W-1:0] uri_offset;
	logic [FIELD_W-1:0] uri_length;
	logic [FIELD_W-1:0] version_offset;
	logic [FIELD_W-1:0] version_length;
	logic [FIELD_W-1:0] body_offset;
	logic has_body;

	http_request_line_parser dut (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_ready(byte_ready),
		.data_byte(data_byte),
		.first_byte(first_byte),
		.message_length(message_length),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.parse_status(parse_status),
		.method_index(method_index),
		.uri_offset(uri_offset),
		.uri_length(uri_length),
		.version_offset(version_offset),
		.version_length(version_length),
		.body_offset(body_offset),
		.has_body(has_body)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// parser shadow state
	int unsigned mdl_pos = 0;
	int unsigned mdl_total = 0;
	line_phase_t mdl_phase = LP_IDLE;
	logic [7:0] mdl_cand = 8'hFF;
	int unsigned mdl_tok = 0;
	logic [15:0] mdl_uri_off = '0;
	logic [15:0] mdl_uri_len = '0;
	logic [15:0] mdl_ver_off = '0;
	logic [15:0] mdl_ver_len = '0;

	result_t pending_verdicts[$];
	logic [7:0] msg_bytes[$];
	int fail_count = 0;
	int bytes_sent = 0;
	int lines_predicted = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int quiet_cycles = 0;

	function automatic string method_name(input logic [2:0] k);
		case (k)
			M_OPTIONS: return "OPTIONS";
			M_GET:     return "GET";
			M_HEAD:    return "HEAD";
			M_POST:    return "POST";
			M_PUT:     return "PUT";
			M_DELETE:  return "DELETE";
			M_TRACE:   return "TRACE";
			default:   return "CONNECT";
		endcase
	endfunction

	function automatic bit is_space(input logic [7:0] c);
		return c == CH_SP || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic logic [7:0] ws_byte();
		case ($urandom_range(5))
			0: return CH_SP;
			1: return CH_TAB;
			2: return CH_LF;
			3: return 8'h0B;
			4: return 8'h0C;
			default: return CH_CR;
		endcase
	endfunction

	function automatic logic [7:0] token_char();
		return 8'($urandom_range(8'h7E, 8'h21));
	endfunction

	task automatic emit_line(input status_t st, input logic [15:0] body, input logic has);
		result_t r;
		int k;
		r = '0;
		r.status = st;
		if (st == ST_OK) begin
			for (k = 7; k >= 0; k--)
				if (mdl_cand[k])
					r.method = k[2:0];
			r.uri_off  = mdl_uri_off;
			r.uri_len  = mdl_uri_len;
			r.ver_off  = mdl_ver_off;
			r.ver_len  = mdl_ver_len;
			r.body_off = body;
			r.has_body = has;
		end
		pending_verdicts.push_back(r);
		lines_predicted++;
		mdl_phase = LP_DONE;
	endtask

	task automatic track_request_byte(input logic [7:0] c, input logic f, input logic [15:0] len);
		int unsigned p, lim, q;
		int k;
		string nm;
		bit again;
		if (f) begin
			mdl_pos = 0;
			mdl_total = len;
			mdl_phase = LP_METHOD;
			mdl_cand = 8'hFF;
			mdl_tok = 0;
			mdl_uri_off = '0;
			mdl_uri_len = '0;
			mdl_ver_off = '0;
			mdl_ver_len = '0;
			if (mdl_total <= MIN_LEN) begin
				emit_line(ST_MALFORMED, '0, 1'b0);
				return;
			end
		end
		if (mdl_phase == LP_IDLE || mdl_phase == LP_DONE)
			return;
		p = mdl_pos;
		if (p >= mdl_total)
			return;
		mdl_pos = (p + 1) & 32'hFFFF;
		lim = mdl_total - 2;
		do begin
			again = 1'b0;
			case (mdl_phase)
				LP_METHOD: begin
					for (k = 0; k < 8; k++) begin
						nm = method_name(k[2:0]);
						if (mdl_cand[k]) begin
							if (p < nm.len()) begin
								if (c != nm[p])
									mdl_cand[k] = 1'b0;
							end else if (p == nm.len() && c == CH_SP) begin
								mdl_cand = 8'h01 << k;
								if (p >= lim)
									emit_line(ST_MALFORMED, '0, 1'b0);
								else
									mdl_phase = LP_SKIP_URI;
								return;
							end else begin
								mdl_cand[k] = 1'b0;
							end
						end
					end
					if (mdl_cand == 8'h00)
						emit_line(ST_MALFORMED, '0, 1'b0);
					return;
				end
				LP_SKIP_URI: begin
					if (p >= lim || c == CH_NUL) begin
						emit_line(ST_MALFORMED, '0, 1'b0);
					end else if (is_space(c)) begin
						if (c == CH_CR)
							mdl_phase = LP_SKIP_URI_CR;
					end else begin
						mdl_tok = p;
						mdl_phase = LP_URI;
					end
					return;
				end
				LP_SKIP_URI_CR: begin
					if (c == CH_LF) begin
						emit_line(ST_MALFORMED, '0, 1'b0);
						return;
					end
					mdl_phase = LP_SKIP_URI;
					again = 1'b1;
				end
				LP_URI: begin
					if (!is_space(c) && c != CH_NUL) begin
						if (p >= lim)
							emit_line(ST_MALFORMED, '0, 1'b0);
						return;
					end
					mdl_uri_off = 16'(mdl_tok);
					mdl_uri_len = 16'(p - mdl_tok);
					if (c == CH_NUL)
						emit_line(ST_MALFORMED, '0, 1'b0);
					else if (c == CH_CR)
						mdl_phase = LP_URI_CR;
					else if (p >= lim)
						emit_line(ST_MALFORMED, '0, 1'b0);
					else
						mdl_phase = LP_SKIP_VER;
					return;
				end
				LP_URI_CR: begin
					// CR after the URI: decided by this byte
					q = p - 1;
					if (c == CH_LF) begin
						if (q >= lim)
							emit_line(ST_INCOMPLETE, '0, 1'b0);
						else
							mdl_phase = LP_BODY;
						return;
					end
					if (q >= lim) begin
						emit_line(ST_MALFORMED, '0, 1'b0);
						return;
					end
					mdl_phase = LP_SKIP_VER;
					again = 1'b1;
				end
				LP_SKIP_VER: begin
					if (p >= lim) begin
						emit_line(ST_MALFORMED, '0, 1'b0);
					end else if (is_space(c)) begin
						if (c == CH_CR)
							mdl_phase = LP_SKIP_VER_CR;
					end else begin
						mdl_tok = p;
						mdl_phase = LP_VER;
					end
					return;
				end
				LP_SKIP_VER_CR: begin
					if (c == CH_LF) begin
						emit_line(ST_MALFORMED, '0, 1'b0);
						return;
					end
					mdl_phase = LP_SKIP_VER;
					again = 1'b1;
				end
				LP_VER: begin
					// NUL is an ordinary version character
					if (!is_space(c)) begin
						if (p >= lim)
							emit_line(ST_MALFORMED, '0, 1'b0);
						return;
					end
					mdl_ver_off = 16'(mdl_tok);
					mdl_ver_len = 16'(p - mdl_tok);
					if (p >= lim)
						emit_line(ST_INCOMPLETE, '0, 1'b0);
					else if (c != CH_CR)
						emit_line(ST_MALFORMED, '0, 1'b0);
					else
						mdl_phase = LP_VER_CR;
					return;
				end
				LP_VER_CR: begin
					if (c != CH_LF)
						emit_line(ST_MALFORMED, '0, 1'b0);
					else
						mdl_phase = LP_BODY;
					return;
				end
				LP_BODY: begin
					emit_line(ST_OK, 16'(p), c != CH_NUL);
					return;
				end
				default: begin
					mdl_phase = LP_DONE;
					return;
				end
			endcase
		end while (again);
	endtask

	// called at a falling edge; returns at the falling edge after the transaction
	task automatic send_byte(input logic [7:0] b, input logic f, input logic [15:0] len);
		while ($urandom_range(99) < send_idle_pct) begin
			byte_valid = 1'b0;
			@(negedge clk);
		end
		byte_valid = 1'b1;
		data_byte = b;
		first_byte = f;
		message_length = len;
		@(posedge clk);
		while (!byte_ready)
			@(posedge clk);
		track_request_byte(b, f, len);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic push_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			msg_bytes.push_back(s[i]);
	endtask

	task automatic send_message(input logic [15:0] len);
		int i;
		for (i = 0; i < msg_bytes.size(); i++)
			send_byte(msg_bytes[i], i == 0, i == 0 ? len : 16'($urandom_range(16'hFFFF)));
	endtask

	function automatic void check_field(input string name, input logic [15:0] exp,
			input logic [15:0] act);
		if (act !== exp) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp, act);
			fail_count++;
		end
	endfunction

	always @(negedge clk)
		result_ready = $urandom_range(99) >= recv_stall_pct;

	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && result_valid && result_ready) begin
			if (pending_verdicts.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual status %0d",
					$time, parse_status);
				fail_count++;
			end else begin
				want = pending_verdicts.pop_front();
				check_field("parse_status", 16'(want.status), 16'(parse_status));
				check_field("method_index", 16'(want.method), 16'(method_index));
				check_field("uri_offset", want.uri_off, uri_offset);
				check_field("uri_length", want.uri_len, uri_length);
				check_field("version_offset", want.ver_off, version_offset);
				check_field("version_length", want.ver_len, version_length);
				check_field("body_offset", want.body_off, body_offset);
				check_field("has_body", 16'(want.has_body), 16'(has_body));
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((byte_valid && byte_ready) || (result_valid && result_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG) begin
				$display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
				$display("http_request_line_parser regression: fail");
				$finish;
			end
		end
	end

	task automatic test_stray_bytes();
		send_byte(8'h47, 1'b0, 16'hFFFF);
		send_byte(8'h00, 1'b0, 16'h0000);
	endtask

	task automatic test_short_lengths();
		send_byte(8'h47, 1'b1, 16'h0000);
		send_byte(8'hFF, 1'b1, 16'(MIN_LEN));
		send_byte(8'h58, 1'b1, 16'(MIN_LEN + 1));
	endtask

	task automatic test_early_restart();
		msg_bytes.delete();
		push_text("GET");
		send_message(16'hFFFF);
	endtask

	task automatic test_decided_tail();
		msg_bytes.delete();
		push_text("PUT /x");
		msg_bytes.push_back(CH_CR);
		msg_bytes.push_back(CH_LF);
		msg_bytes.push_back(CH_NUL);
		push_text("ab");
		send_message(16'(msg_bytes.size()));
	endtask

	task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int budget,
			input int want_lines);
		int start_bytes, start_lines, n, i, lk;
		logic [15:0] len;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		start_bytes = bytes_sent;
		start_lines = lines_predicted;
		while (bytes_sent - start_bytes < budget || lines_predicted - start_lines < want_lines) begin
			msg_bytes.delete();
			if ($urandom_range(99) < 8) begin
				n = $urandom_range(24, 1);
				repeat (n) msg_bytes.push_back(8'($urandom_range(255)));
			end else begin
				push_text(method_name(3'($urandom_range(7))));
				if ($urandom_range(9) == 0)
					msg_bytes[$urandom_range(msg_bytes.size() - 1)] = 8'($urandom_range(255));
				msg_bytes.push_back($urandom_range(14) == 0 ? ws_byte() : CH_SP);
				repeat ($urandom_range(3) == 0 ? $urandom_range(2, 1) : 0)
					msg_bytes.push_back(ws_byte());
				n = $urandom_range(6, 1);
				for (i = 0; i < n; i++)
					msg_bytes.push_back($urandom_range(29) == 0 ? CH_NUL : token_char());
				if ($urandom_range(3) != 0) begin
					repeat ($urandom_range(2, 1))
						msg_bytes.push_back($urandom_range(7) == 0 ? ws_byte() : CH_SP);
					if ($urandom_range(2) != 0) begin
						push_text("HTTP/1.");
						msg_bytes.push_back(8'(8'h30 + $urandom_range(1)));
					end else begin
						n = $urandom_range(8, 1);
						for (i = 0; i < n; i++)
							msg_bytes.push_back($urandom_range(9) == 0 ? CH_NUL : token_char());
					end
				end
				case ($urandom_range(19))
					0: msg_bytes.push_back(CH_CR);
					1: msg_bytes.push_back(CH_LF);
					2: begin
						msg_bytes.push_back(CH_CR);
						msg_bytes.push_back(token_char());
					end
					3: begin
						msg_bytes.push_back(CH_SP);
						msg_bytes.push_back(CH_CR);
						msg_bytes.push_back(CH_LF);
					end
					default: begin
						msg_bytes.push_back(CH_CR);
						msg_bytes.push_back(CH_LF);
					end
				endcase
				n = $urandom_range(4);
				for (i = 0; i < n; i++)
					msg_bytes.push_back((i == 0 && $urandom_range(3) == 0) ? CH_NUL :
						8'($urandom_range(255)));
			end
			// mostly exact lengths; the rest truncate, overrun, are short or are random
			lk = $urandom_range(99);
			if (lk < 70)
				len = 16'(msg_bytes.size());
			else if (lk < 80)
				len = 16'(msg_bytes.size() - $urandom_range(3));
			else if (lk < 88)
				len = 16'(msg_bytes.size() + $urandom_range(3, 1));
			else if (lk < 93)
				len = 16'($urandom_range(MIN_LEN));
			else
				len = 16'($urandom_range(16'hFFFF));
			send_message(len);
		end
	endtask

	initial begin
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		test_stray_bytes();
		test_short_lengths();
		test_early_restart();
		test_decided_tail();
		test_random_traffic(0, 0, 235, 12);
		test_random_traffic(55, 0, 235, 12);
		test_random_traffic(0, 55, 235, 12);
		test_random_traffic(37, 37, 235, 12);
		byte_valid = 1'b0;
		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("http_request_line_parser regression: pass");
		else
			$display("http_request_line_parser regression: fail");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/hrlp_pkg.sv
rtl/hrlp_front.sv
rtl/hrlp_fifo.sv
rtl/hrlp_back.sv
rtl/http_request_line_parser.sv
tb/tb.sv
